// ===== rtl/morc_pkg.sv =====
// Package for the morphological opening/closing filter.
// Holds the transaction payload types, the pipeline token and the min/max helper.
// No dependencies.
package morc_pkg;

    localparam int PIX_W  = 32;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam int HB     = 13;
    localparam int MAX_H  = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_LEVELS = 2'd2;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_in;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_of_frame;
    } out_t;

    // One pipeline slot: present marks a step, pix marks a real pixel in it.
    typedef struct packed {
        logic             present;
        logic             pix;
        logic [PIX_W-1:0] value;
    } tok_t;

    function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic use_max);
        logic [PIX_W-1:0] r;
        if (use_max) begin
            r = (a > b) ? a : b;
        end else begin
            r = (a < b) ? a : b;
        end
        return r;
    endfunction

endpackage

// ===== rtl/morc_cell.sv =====
// One erosion or dilation pass: a circular pixel history in two memories.
// Depends on morc_pkg.
module morc_cell import morc_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               clr,
    input  logic                               en,
    input  logic                               use_max,
    input  logic [$clog2(MAX_WIDTH+3)-1:0]     w,
    input  logic [HB-1:0]                      h,
    input  tok_t                               tok_in,
    output tok_t                               tok_out
);

    localparam int WB    = $clog2(MAX_WIDTH + 3);
    localparam int DEPTH = 2 * MAX_WIDTH + 4;
    localparam int AW    = $clog2(DEPTH);

    // History memories; both hold the same data so four reads fit two ports each.
    logic [PIX_W-1:0] memx [DEPTH];
    logic [PIX_W-1:0] memy [DEPTH];

    logic [AW-1:0] wr_reg, wr_next;
    logic [WB-1:0] pend_reg, pend_next;
    logic [WB-1:0] ix_reg, ix_next, ox_reg, ox_next;
    logic [HB-1:0] iy_reg, iy_next, oy_reg, oy_next;
    logic          tail_reg, tail_next;

    logic          emit, we;
    logic [AW:0]   a_wide, up_wide, dn_wide;
    logic [AW-1:0] a_addr, r_addr, up_addr, dn_addr;

    logic             b_present_reg, b_emit_reg;
    logic             b_l_reg, b_r_reg, b_u_reg, b_d_reg;
    logic [PIX_W-1:0] rd_c_reg, rd_r_reg, rd_u_reg, rd_d_reg, prev_reg;
    logic [PIX_W-1:0] result;
    tok_t             out_reg;

    // Write side and emit decision for the arriving step.
    always_comb begin
        wr_next   = wr_reg;
        pend_next = pend_reg;
        ix_next   = ix_reg;
        iy_next   = iy_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        tail_next = tail_reg;
        emit      = 1'b0;
        we        = 1'b0;
        if (tok_in.present) begin
            if (tok_in.pix) begin
                we        = 1'b1;
                wr_next   = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
                pend_next = pend_reg + 1'b1;
                tail_next = (ix_reg == w - 1'b1) && (iy_reg == h - 1'b1);
                if (ix_reg == w - 1'b1) begin
                    ix_next = '0;
                    iy_next = (iy_reg == h - 1'b1) ? '0 : iy_reg + 1'b1;
                end else begin
                    ix_next = ix_reg + 1'b1;
                end
                emit = pend_next > (w + 1'b1);
            end else begin
                emit = tail_reg && (pend_reg != '0);
            end
        end
        if (emit) begin
            pend_next = pend_next - 1'b1;
            if (ox_reg == w - 1'b1) begin
                ox_next = '0;
                oy_next = (oy_reg == h - 1'b1) ? '0 : oy_reg + 1'b1;
            end else begin
                ox_next = ox_reg + 1'b1;
            end
        end
    end

    // Read addresses: center, right, up and down neighbors.
    always_comb begin
        logic [AW:0] wrx, pdx, wx;
        wrx = {1'b0, wr_next};
        pdx = (AW+1)'(pend_next + (emit ? 1'b0 : 1'b0));
        wx  = (AW+1)'(w);
        if (emit) begin
            pdx = (AW+1)'(pend_next) + 1'b1;
        end
        a_wide  = (wrx >= pdx) ? wrx - pdx : wrx + (AW+1)'(DEPTH) - pdx;
        a_addr  = a_wide[AW-1:0];
        r_addr  = (a_addr == AW'(DEPTH - 1)) ? '0 : a_addr + 1'b1;
        up_wide = (a_wide >= wx) ? a_wide - wx : a_wide + (AW+1)'(DEPTH) - wx;
        dn_wide = a_wide + wx;
        if (dn_wide >= (AW+1)'(DEPTH)) begin
            dn_wide = dn_wide - (AW+1)'(DEPTH);
        end
        up_addr = up_wide[AW-1:0];
        dn_addr = dn_wide[AW-1:0];
    end

    // Memory write and registered reads.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                memx[wr_reg] <= tok_in.value;
                memy[wr_reg] <= tok_in.value;
            end
            rd_c_reg <= memx[a_addr];
            rd_r_reg <= memx[r_addr];
            rd_u_reg <= memy[up_addr];
            rd_d_reg <= memy[dn_addr];
        end
    end

    // Neighbor selection with the frame border left out.
    always_comb begin
        result = rd_c_reg;
        if (b_l_reg) result = pick(result, prev_reg, use_max);
        if (b_r_reg) result = pick(result, rd_r_reg, use_max);
        if (b_u_reg) result = pick(result, rd_u_reg, use_max);
        if (b_d_reg) result = pick(result, rd_d_reg, use_max);
    end

    // Control state, second stage and output slot.
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            wr_reg        <= '0;
            pend_reg      <= '0;
            ix_reg        <= '0;
            iy_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            tail_reg      <= 1'b0;
            b_present_reg <= 1'b0;
            b_emit_reg    <= 1'b0;
            out_reg       <= '0;
        end else if (en) begin
            wr_reg        <= wr_next;
            pend_reg      <= pend_next;
            ix_reg        <= ix_next;
            iy_reg        <= iy_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            tail_reg      <= tail_next;
            b_present_reg <= tok_in.present;
            b_emit_reg    <= emit;
            out_reg       <= '{present: b_present_reg, pix: b_emit_reg, value: result};
        end
    end

    // Border flags and the previous center travel without reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            b_l_reg <= ox_reg != '0;
            b_r_reg <= (ox_reg + 1'b1) < w;
            b_u_reg <= oy_reg != '0;
            b_d_reg <= (oy_reg + 1'b1) < h;
            if (b_emit_reg) begin
                prev_reg <= rd_c_reg;
            end
        end
    end

    assign tok_out = out_reg;

endmodule

// ===== rtl/morph_open_close_filter.sv =====
// Each active pass registers its memory reads and then its output slot; an input register
// and the two-entry output buffer come on top of the W+1 item lag each pass has by nature.
// Throughput: one transaction per cycle while the output buffer has room; each pass reads four
// history words a cycle from two dual-read memories, which sets that rate.
// Reset (aresetn low, synchronous) clears all counters and the pipeline; history
// memories are not cleared. A write to the width, height or levels register also clears the pipeline.
module morph_open_close_filter import morc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_LEVELS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int WB    = $clog2(MAX_WIDTH + 3);
    localparam int CELLS = 2 * MAX_LEVELS;
    localparam int TB    = $clog2(CELLS + 1);
    localparam int CB    = $clog2(MAX_WIDTH * MAX_H + 1);
    localparam int RST_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;

    logic [10:0]   cw_reg;
    logic [HB-1:0] ch_reg;
    logic [3:0]    cl_reg;
    logic [WB-1:0] w_reg;
    logic [HB-1:0] h_reg;
    logic [TB-1:0] mag_reg, total_reg;
    logic          neg_reg;
    logic [CB-1:0] whm1_reg, cnt_reg;
    logic          clr, en, push, pop;
    logic [3:0]    mag_raw;
    tok_t          in_reg;
    tok_t          toks [CELLS+1];
    tok_t          tap;
    out_t          ent0_reg, ent1_reg, new_ent;
    logic [1:0]    count_reg;

    assign cfg_ready = 1'b1;
    assign clr = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                               cfg_index == REG_LEVELS);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= 11'd640;
            ch_reg <= HB'(480);
            cl_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH:  cw_reg <= cfg_data[10:0];
                REG_HEIGHT: ch_reg <= cfg_data[HB-1:0];
                REG_LEVELS: cl_reg <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    // Saturated frame size and pass count, held in registers.
    assign mag_raw = cl_reg[3] ? 4'(-cl_reg) : cl_reg;
    always_ff @(posedge aclk) begin
        logic [WB-1:0] wv;
        logic [HB-1:0] hv;
        logic [TB-1:0] mv;
        if (32'(cw_reg) < 2) begin
            wv = WB'(2);
        end else if (32'(cw_reg) > MAX_WIDTH) begin
            wv = WB'(MAX_WIDTH);
        end else begin
            wv = WB'(cw_reg);
        end
        if (ch_reg < HB'(2)) begin
            hv = HB'(2);
        end else if (ch_reg > HB'(MAX_H)) begin
            hv = HB'(MAX_H);
        end else begin
            hv = ch_reg;
        end
        mv = (32'(mag_raw) > MAX_LEVELS) ? TB'(MAX_LEVELS) : TB'(mag_raw);
        if (!aresetn) begin
            w_reg     <= WB'(RST_W);
            h_reg     <= HB'(480);
            mag_reg   <= '0;
            total_reg <= '0;
            neg_reg   <= 1'b0;
            whm1_reg  <= CB'(RST_W * 480 - 1);
        end else begin
            w_reg     <= wv;
            h_reg     <= hv;
            mag_reg   <= mv;
            total_reg <= TB'({mv, 1'b0});
            neg_reg   <= cl_reg[3];
            whm1_reg  <= CB'(wv) * CB'(hv) - 1'b1;
        end
    end

    // The pipeline advances whenever the output buffer has room.
    assign en      = (count_reg != 2'd2);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            in_reg <= '0;
        end else if (en) begin
            in_reg <= '{present: s_valid, pix: !s_data.action, value: s_data.pixel_in};
        end
    end

    assign toks[0] = in_reg;

    // Pass cells: erosions then dilations, or the reverse.
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        logic um;
        assign um = (TB'(i) < mag_reg) ? !neg_reg : neg_reg;
        morc_cell #(.MAX_WIDTH(MAX_WIDTH)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clr     (clr),
            .en      (en),
            .use_max (um),
            .w       (w_reg),
            .h       (h_reg),
            .tok_in  (toks[i]),
            .tok_out (toks[i+1])
        );
    end

    assign tap     = toks[total_reg];
    assign push    = en && tap.present && tap.pix;
    assign pop     = m_valid && m_ready;
    assign new_ent = '{pixel_out: tap.value, last_of_frame: cnt_reg == whm1_reg};

    // Position of the next result within its frame.
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            cnt_reg <= '0;
        end else if (push) begin
            cnt_reg <= (cnt_reg == whm1_reg) ? '0 : cnt_reg + 1'b1;
        end
    end

    // Two-entry output buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            case ({push, pop})
                2'b11: count_reg <= count_reg;
                2'b10: count_reg <= count_reg + 1'b1;
                2'b01: count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ent0_reg <= (push && count_reg == 2'd1) ? new_ent : ent1_reg;
            if (push && count_reg != 2'd1) begin
                ent1_reg <= new_ent;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                ent0_reg <= new_ent;
            end else begin
                ent1_reg <= new_ent;
            end
        end
    end

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = ent0_reg;

endmodule

// ===== rtl/morc_checker.sv =====
// Port-level checker for the morphological filter, bound to the top level.
// Depends on morc_pkg and morph_open_close_filter.
module morc_checker import morc_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data,
    input logic cfg_valid,
    input logic cfg_ready
);

    // A waiting result transaction holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output side.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Configuration writes are never back-pressured.
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration stalled");

    // Input is taken whenever no result is waiting.
    a_in: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind morph_open_close_filter morc_checker u_morc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== tb/morph_open_close_checker.sv =====
// Checker for the morphological opening/closing filter: watches all three channels,
// predicts every result transaction and compares it with what the block delivers.
// Depends on morc_pkg for the payload types and register indexes.
`timescale 1ns / 100ps

module morph_open_close_checker import morc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_t               s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_t              m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output int                errors,
    output int                owed
);

    localparam int LINE_CAP = 1024;
    localparam int LEVEL_CAP = 4;
    localparam int HIST = 2 * LINE_CAP + 4;
    localparam int CELLS = 2 * LEVEL_CAP;

    // Shadow registers.
    logic [10:0]       width_reg;
    logic [12:0]       height_reg;
    logic signed [3:0] levels_reg;

    // Per-pass history and position tracking.
    logic [PIX_W-1:0] hist [CELLS][HIST];
    int unsigned wptr [CELLS];
    int unsigned held [CELLS];
    int unsigned in_x [CELLS];
    int unsigned in_y [CELLS];
    int unsigned out_x [CELLS];
    int unsigned out_y [CELLS];
    bit          frame_done [CELLS];
    int unsigned frame_pos;

    out_t pixels_due [$];

    task automatic report(input string what, input logic [PIX_W-1:0] got,
                          input logic [PIX_W-1:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic clear_pipeline();
        for (int i = 0; i < CELLS; i++) begin
            wptr[i] = 0;
            held[i] = 0;
            in_x[i] = 0;
            in_y[i] = 0;
            out_x[i] = 0;
            out_y[i] = 0;
            frame_done[i] = 0;
        end
        frame_pos = 0;
    endtask

    function automatic logic [PIX_W-1:0] pick_val(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b,
                                                   input bit use_max);
        if (use_max) return (a > b) ? a : b;
        return (a < b) ? a : b;
    endfunction

    // One erosion or dilation pass; v says whether a pixel moves on.
    task automatic pass_step(input int c, inout bit v, inout logic [PIX_W-1:0] val,
                             input bit use_max, input int unsigned w, input int unsigned h);
        bit ends_frame;
        bit fire;
        int unsigned a;
        logic [PIX_W-1:0] r;
        if (v) begin
            ends_frame = (in_x[c] == w - 1) && (in_y[c] == h - 1);
            hist[c][wptr[c]] = val;
            wptr[c] = (wptr[c] + 1) % HIST;
            held[c]++;
            in_x[c]++;
            if (in_x[c] >= w) begin
                in_x[c] = 0;
                in_y[c]++;
                if (in_y[c] >= h) in_y[c] = 0;
            end
            frame_done[c] = ends_frame;
            fire = held[c] > w + 1;
        end else begin
            fire = frame_done[c] && held[c] > 0;
        end
        v = fire;
        if (!fire) return;
        a = (wptr[c] + HIST - held[c]) % HIST;
        r = hist[c][a];
        if (out_x[c] > 0) r = pick_val(r, hist[c][(a + HIST - 1) % HIST], use_max);
        if (out_x[c] + 1 < w) r = pick_val(r, hist[c][(a + 1) % HIST], use_max);
        if (out_y[c] > 0) r = pick_val(r, hist[c][(a + HIST - w) % HIST], use_max);
        if (out_y[c] + 1 < h) r = pick_val(r, hist[c][(a + w) % HIST], use_max);
        held[c]--;
        out_x[c]++;
        if (out_x[c] >= w) begin
            out_x[c] = 0;
            out_y[c]++;
            if (out_y[c] >= h) out_y[c] = 0;
        end
        val = r;
    endtask

    // Run one input transaction through the active passes.
    task automatic predict_filter(input in_t item);
        int unsigned w;
        int unsigned h;
        int unsigned mag;
        bit neg;
        bit v;
        logic [PIX_W-1:0] val;
        out_t res;
        w = (width_reg < 2) ? 2 : (width_reg > LINE_CAP) ? LINE_CAP : width_reg;
        h = (height_reg < 2) ? 2 : (height_reg > MAX_H) ? MAX_H : height_reg;
        neg = levels_reg < 0;
        mag = neg ? -levels_reg : levels_reg;
        if (mag > LEVEL_CAP) mag = LEVEL_CAP;
        v = !item.action;
        val = item.pixel_in;
        for (int i = 0; i < 2 * mag; i++) begin
            pass_step(i, v, val, (i < mag) ? !neg : neg, w, h);
        end
        if (!v) return;
        res.pixel_out = val;
        res.last_of_frame = (frame_pos == w * h - 1);
        pixels_due.push_back(res);
        frame_pos++;
        if (frame_pos >= w * h) frame_pos = 0;
    endtask

    // Observe, compare and predict on every rising clock edge.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            width_reg = 11'd640;
            height_reg = 13'd480;
            levels_reg = 4'sd0;
            clear_pipeline();
            pixels_due.delete();
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    report("unexpected transaction", m_data.pixel_out, '0);
                end else begin
                    want = pixels_due.pop_front();
                    if (m_data.pixel_out !== want.pixel_out)
                        report("pixel_out", m_data.pixel_out, want.pixel_out);
                    if (m_data.last_of_frame !== want.last_of_frame)
                        report("last_of_frame", m_data.last_of_frame, want.last_of_frame);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WIDTH: begin
                        width_reg = cfg_data[10:0];
                        clear_pipeline();
                    end
                    REG_HEIGHT: begin
                        height_reg = cfg_data[12:0];
                        clear_pipeline();
                    end
                    REG_LEVELS: begin
                        levels_reg = cfg_data[3:0];
                        clear_pipeline();
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_filter(s_data);
        end
        owed <= pixels_due.size();
    end

endmodule

// ===== tb/morph_open_close_filter_tb.sv =====
// Top of the testbench for the morphological opening/closing filter: drives frames,
// drain ticks and register writes with random idling and gives the verdict.
// Depends on morc_pkg, morph_open_close_filter and morph_open_close_checker.
`timescale 1ns / 100ps

module morph_open_close_filter_tb;
    import morc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_t               s_data;
    logic              m_valid;
    logic              m_ready;
    out_t              m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int                errors;
    int                owed;
    int                cycles = 0;
    int                items_sent;
    bit                steady;
    int                eff_w;
    int                eff_h;
    int                eff_mag;

    morph_open_close_filter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    morph_open_close_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .owed(owed)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int idle_draw();
        if (steady || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    // Result side: random backpressure per transaction.
    initial begin
        int n;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            n = idle_draw();
            if (n > 0) begin
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send(input logic action, input logic [PIX_W-1:0] pix);
        int n;
        n = idle_draw();
        if (n > 0) begin
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{action: action, pixel_in: pix};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 0;
        @(posedge aclk);
        while (owed != 0) @(posedge aclk);
    endtask

    // Register writes happen only once every expected result has come out; upper bits carry noise.
    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int value);
        int bits;
        wait_drained();
        repeat (40) @(posedge aclk);
        bits = (idx == REG_WIDTH) ? 11 : (idx == REG_HEIGHT) ? 13 : 4;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_DW'((value & ((1 << bits) - 1)) | ($urandom << bits));
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        case (idx)
            REG_WIDTH: eff_w = (value % 2048 < 2) ? 2 : (value % 2048 > 1024) ? 1024
                                                  : value % 2048;
            REG_HEIGHT: eff_h = (value % 8192 < 2) ? 2 : (value % 8192 > MAX_H) ? MAX_H
                                                   : value % 8192;
            REG_LEVELS: begin
                eff_mag = ((value & 15) >= 8) ? 16 - (value & 15) : (value & 15);
                if (eff_mag > 4) eff_mag = 4;
            end
            default: ;
        endcase
    endtask

    function automatic logic [PIX_W-1:0] pixel_value(input int style);
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? '1 : '0;
            2: return $urandom_range(0, 7);
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    // One frame of pixels with stray bubbles, then a full or partial flush.
    task automatic send_frame(input bit full_flush);
        int style;
        int drains;
        style = $urandom_range(0, 3);
        for (int i = 0; i < eff_w * eff_h; i++) begin
            if ($urandom_range(0, 15) == 0) send(1, $urandom);
            send(0, pixel_value(style));
        end
        drains = 2 * eff_mag * (eff_w + 1);
        if (!full_flush) drains = $urandom_range(0, drains);
        repeat (drains) send(1, $urandom);
    endtask

    initial begin
        int frames;
        bit pressed;
        s_valid = 0;
        s_data = '0;
        cfg_valid = 0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        items_sent = 0;
        steady = 0;
        pressed = 0;
        eff_w = 640;
        eff_h = 480;
        eff_mag = 0;
        aresetn = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Reset values: pass-through, extreme pixels, drain gives nothing.
        send(0, '0);
        send(0, '1);
        send(0, 32'h5);
        send(1, '1);
        cfg_write(REG_WIDTH, 2);
        cfg_write(REG_HEIGHT, 2);
        for (int lv = -1; lv <= 1; lv += 2) begin
            cfg_write(REG_LEVELS, lv);
            send(0, '0);
            send(0, '1);
            send(0, 32'h1);
            send(0, 32'hFFFF_FFFE);
            repeat (6) send(1, '0);
        end
        cfg_write(3, 5);

        // Saturated levels in both directions.
        cfg_write(REG_WIDTH, 3);
        cfg_write(REG_HEIGHT, 3);
        cfg_write(REG_LEVELS, -8);
        send_frame(1);
        cfg_write(REG_LEVELS, 7);
        send_frame(1);

        // Random small frames across all level settings.
        while (items_sent < 330) begin
            steady = ($urandom_range(0, 4) == 0);
            cfg_write(REG_WIDTH, $urandom_range(2, 9));
            cfg_write(REG_HEIGHT, $urandom_range(2, 6));
            cfg_write(REG_LEVELS, $urandom_range(0, 8) - 4);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                send_frame(f == frames - 1 || $urandom_range(0, 1));
                if (!pressed && f == 0 && frames > 1) begin
                    wait_drained();
                    pressed = 1;
                end
            end
        end

        // Widest and tallest frames, saturated from out-of-range writes and then set in range.
        steady = 1;
        cfg_write(REG_WIDTH, 2047);
        cfg_write(REG_HEIGHT, 0);
        cfg_write(REG_LEVELS, 1);
        repeat (20) send(0, $urandom);
        cfg_write(REG_WIDTH, 1);
        cfg_write(REG_HEIGHT, 8191);
        cfg_write(REG_LEVELS, 0);
        repeat (20) send(0, $urandom);
        cfg_write(REG_WIDTH, 1024);
        cfg_write(REG_HEIGHT, 4096);
        cfg_write(REG_LEVELS, -2);
        repeat (20) send(0, $urandom);
        steady = 0;

        wait_drained();
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== morph_open_close_filter.f =====
rtl/morc_pkg.sv
rtl/morc_cell.sv
rtl/morph_open_close_filter.sv
rtl/morc_checker.sv
tb/morph_open_close_checker.sv
tb/morph_open_close_filter_tb.sv
